/* design/fcnlp_pkg.sv */
// ----------------------------------------------------------------------------
// fcnlp_pkg
// Types, constants and lookup helpers of the FIFO cache with next-line
// prefetch.
// ----------------------------------------------------------------------------
`default_nettype none

package fcnlp_pkg;

  localparam int MAX_SETS   = 64;
  localparam int MAX_WAYS   = 8;
  localparam int ADDR_BITS  = 48;
  localparam int COUNT_BITS = 32;

  localparam int TAG_W     = ADDR_BITS;
  localparam int SET_IDX_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
  localparam int SHAMT_W   = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS        = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PREFETCH_ENABLE = CFG_IDX_W'(3);

  localparam logic [3:0] OFFSET_BITS_RST = 4'd6;
  localparam logic [2:0] SET_BITS_RST    = 3'd6;
  localparam logic [3:0] WAYS_RST        = 4'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEMAND,
    ST_PREFETCH
  } state_t;

  typedef struct packed {
    logic                 cmd;
    logic [ADDR_BITS-1:0] address;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  reads_added;
    logic        write_added;
    logic [31:0] total_reads;
    logic [31:0] total_writes;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
  } out_t;

  typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_t;

  typedef struct packed {
    logic [WAY_W-1:0]    ptr;
    logic [MAX_WAYS-1:0] valid;
  } meta_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic [WAY_W-1:0] ptr_nxt;
  } lookup_t;

  function automatic logic [SET_IDX_W-1:0] set_of(input logic [ADDR_BITS-1:0] addr,
                                                  input logic [3:0] offset,
                                                  input logic [2:0] sb);
    logic [ADDR_BITS-1:0] shifted;
    logic [SET_IDX_W:0]   mask;
    shifted = addr >> offset;
    mask    = ((SET_IDX_W+1)'(1) << sb) - (SET_IDX_W+1)'(1);
    return shifted[SET_IDX_W-1:0] & mask[SET_IDX_W-1:0];
  endfunction

  function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_BITS-1:0] addr,
                                              input logic [3:0] offset,
                                              input logic [2:0] sb);
    logic [SHAMT_W-1:0] sh;
    sh = SHAMT_W'(offset) + SHAMT_W'(sb);
    return TAG_W'(addr >> sh);
  endfunction

  function automatic lookup_t lookup(input tag_row_t tags,
                                     input meta_t meta,
                                     input logic [TAG_W-1:0] tag,
                                     input logic [WAY_CNT_W-1:0] ways);
    lookup_t             res;
    logic                found_free;
    logic [WAY_W-1:0]    free_way;
    logic [WAY_W-1:0]    victim;
    logic [WAY_CNT_W-1:0] vp1;
    res        = '0;
    found_free = 1'b0;
    free_way   = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (WAY_CNT_W'(w) < ways) begin
        if (meta.valid[w] && tags[w] == tag) begin
          res.hit = 1'b1;
          res.way = WAY_W'(w);
        end
        if (!meta.valid[w]) begin
          found_free = 1'b1;
          free_way   = WAY_W'(w);
        end
      end
    end
    if (!res.hit) begin
      if (found_free) begin
        res.way     = free_way;
        res.ptr_nxt = meta.ptr;
      end else begin
        victim      = (WAY_CNT_W'(meta.ptr) >= ways) ? '0 : meta.ptr;
        vp1         = WAY_CNT_W'(victim) + WAY_CNT_W'(1);
        res.way     = victim;
        res.ptr_nxt = (vp1 == ways) ? '0 : vp1[WAY_W-1:0];
      end
    end else begin
      res.ptr_nxt = meta.ptr;
    end
    return res;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] cnt,
                                                   input logic [1:0] inc);
    logic [COUNT_BITS:0] sum;
    sum = {1'b0, cnt} + (COUNT_BITS+1)'(inc);
    return sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/fifo_cache_with_next_line_prefetch.sv */
// ----------------------------------------------------------------------------
// fifo_cache_with_next_line_prefetch
// Tag-only set-associative write-through cache with FIFO replacement and
// optional next-line prefetch; reports per-access outcome and counters.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one access transaction (cmd, address).
//   out_valid/out_stall/out_data carry one result transaction per access:
//   hit, reads added, write added and the four saturating counters.
//   cfg_we/cfg_idx/cfg_wdata write offset_bits, set_bits, ways_in_use and
//   prefetch_enable; write them only while the block is idle.
// Access flow:
//   The set row is read from the tag and state memories at the accept edge
//   and registered; a miss updates it in the demand state. A miss with
//   prefetch enabled also reads the next block's set and, if that misses,
//   updates it in the prefetch state. One access is in flight at a time.
// Reset:
//   Synchronous, active low: registers take their reset values, counters
//   clear and a per-set valid flag marks all set rows empty (no sweep).
// Stall:
//   A finished result waits in the output register; the next access is
//   accepted meanwhile, and completes once that register has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_cache_with_next_line_prefetch (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire fcnlp_pkg::in_t                       in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output fcnlp_pkg::out_t                           out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [fcnlp_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [fcnlp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [3:0] offset_bits_r;
  logic [2:0] set_bits_r;
  logic [3:0] ways_in_use_r;
  logic       prefetch_enable_r;

  fcnlp_pkg::state_t state_r, state_nxt;

  logic                                 cmd_r;
  logic [fcnlp_pkg::ADDR_BITS-1:0]      addr_r;
  logic [fcnlp_pkg::ADDR_BITS-1:0]      next_r;

  fcnlp_pkg::tag_row_t                  tag_mem [fcnlp_pkg::MAX_SETS];
  fcnlp_pkg::meta_t                     meta_mem [fcnlp_pkg::MAX_SETS];
  logic [fcnlp_pkg::MAX_SETS-1:0]       row_init_r;

  fcnlp_pkg::tag_row_t                  tag_rd_r;
  fcnlp_pkg::meta_t                     meta_rd_r;
  logic                                 init_rd_r;
  logic                                 fwd_r;
  fcnlp_pkg::tag_row_t                  fwd_tags_r;
  fcnlp_pkg::meta_t                     fwd_meta_r;

  logic [fcnlp_pkg::COUNT_BITS-1:0]     rd_cnt_r, wr_cnt_r, hit_cnt_r, miss_cnt_r;
  logic [fcnlp_pkg::COUNT_BITS-1:0]     rd_cnt_nxt, wr_cnt_nxt, hit_cnt_nxt, miss_cnt_nxt;

  logic                                 out_valid_r;
  fcnlp_pkg::out_t                      out_data_r;

  logic                                 in_accept;
  logic                                 out_free;
  logic [2:0]                           sb_eff;
  logic [fcnlp_pkg::WAY_CNT_W-1:0]      ways_eff;
  logic [fcnlp_pkg::ADDR_BITS-1:0]      cur_addr;
  logic [fcnlp_pkg::SET_IDX_W-1:0]      cur_set;
  logic [fcnlp_pkg::SET_IDX_W-1:0]      in_set;
  logic [fcnlp_pkg::SET_IDX_W-1:0]      next_set;
  logic [fcnlp_pkg::TAG_W-1:0]          cur_tag;
  fcnlp_pkg::tag_row_t                  row_tags;
  fcnlp_pkg::meta_t                     row_meta;
  fcnlp_pkg::lookup_t                   lk;
  fcnlp_pkg::tag_row_t                  wr_tags;
  fcnlp_pkg::meta_t                     wr_meta;

  logic                                 rd_en;
  logic [fcnlp_pkg::SET_IDX_W-1:0]      rd_set;
  logic                                 wr_en;
  logic                                 finish;
  logic                                 hit_o;
  logic [1:0]                           reads_o;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r     <= fcnlp_pkg::OFFSET_BITS_RST;
      set_bits_r        <= fcnlp_pkg::SET_BITS_RST;
      ways_in_use_r     <= fcnlp_pkg::WAYS_RST;
      prefetch_enable_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        fcnlp_pkg::REG_OFFSET_BITS:     offset_bits_r     <= cfg_wdata[3:0];
        fcnlp_pkg::REG_SET_BITS:        set_bits_r        <= cfg_wdata[2:0];
        fcnlp_pkg::REG_WAYS_IN_USE:     ways_in_use_r     <= cfg_wdata[3:0];
        fcnlp_pkg::REG_PREFETCH_ENABLE: prefetch_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sb_eff = (int'(set_bits_r) > fcnlp_pkg::SET_IDX_W) ? 3'(fcnlp_pkg::SET_IDX_W)
                                                       : set_bits_r;
    if (ways_in_use_r == 4'd0) begin
      ways_eff = fcnlp_pkg::WAY_CNT_W'(1);
    end else if (int'(ways_in_use_r) > fcnlp_pkg::MAX_WAYS) begin
      ways_eff = fcnlp_pkg::WAY_CNT_W'(fcnlp_pkg::MAX_WAYS);
    end else begin
      ways_eff = fcnlp_pkg::WAY_CNT_W'(ways_in_use_r);
    end
  end

  assign in_stall  = (state_r != fcnlp_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Set row lookup and modify
  always_comb begin
    cur_addr = (state_r == fcnlp_pkg::ST_PREFETCH) ? next_r : addr_r;
    cur_set  = fcnlp_pkg::set_of(cur_addr, offset_bits_r, sb_eff);
    cur_tag  = fcnlp_pkg::tag_of(cur_addr, offset_bits_r, sb_eff);
    in_set   = fcnlp_pkg::set_of(in_data.address, offset_bits_r, sb_eff);
    next_set = fcnlp_pkg::set_of(next_r, offset_bits_r, sb_eff);
    if (state_r == fcnlp_pkg::ST_PREFETCH && fwd_r) begin
      row_tags = fwd_tags_r;
      row_meta = fwd_meta_r;
    end else begin
      row_tags = tag_rd_r;
      row_meta = init_rd_r ? meta_rd_r : '0;
    end
    lk                    = fcnlp_pkg::lookup(row_tags, row_meta, cur_tag, ways_eff);
    wr_tags               = row_tags;
    wr_tags[lk.way]       = cur_tag;
    wr_meta.valid         = row_meta.valid;
    wr_meta.valid[lk.way] = 1'b1;
    wr_meta.ptr           = lk.ptr_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_set    = in_set;
    wr_en     = 1'b0;
    finish    = 1'b0;
    hit_o     = 1'b0;
    reads_o   = 2'd0;
    case (state_r)
      fcnlp_pkg::ST_IDLE: begin
        if (in_accept) begin
          rd_en     = 1'b1;
          state_nxt = fcnlp_pkg::ST_DEMAND;
        end
      end
      fcnlp_pkg::ST_DEMAND: begin
        if (lk.hit) begin
          if (out_free) begin
            finish    = 1'b1;
            hit_o     = 1'b1;
            state_nxt = fcnlp_pkg::ST_IDLE;
          end
        end else if (prefetch_enable_r) begin
          wr_en     = 1'b1;
          rd_en     = 1'b1;
          rd_set    = next_set;
          state_nxt = fcnlp_pkg::ST_PREFETCH;
        end else if (out_free) begin
          wr_en     = 1'b1;
          finish    = 1'b1;
          reads_o   = 2'd1;
          state_nxt = fcnlp_pkg::ST_IDLE;
        end
      end
      fcnlp_pkg::ST_PREFETCH: begin
        if (out_free) begin
          wr_en     = !lk.hit;
          finish    = 1'b1;
          reads_o   = lk.hit ? 2'd1 : 2'd2;
          state_nxt = fcnlp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fcnlp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcnlp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r  <= in_data.cmd;
      addr_r <= in_data.address;
      next_r <= in_data.address + (fcnlp_pkg::ADDR_BITS'(1) << offset_bits_r);
    end
  end

  // Tag and state memories
  always_ff @(posedge clk) begin
    if (rd_en) begin
      tag_rd_r  <= tag_mem[rd_set];
      meta_rd_r <= meta_mem[rd_set];
    end
    if (wr_en) begin
      tag_mem[cur_set]  <= wr_tags;
      meta_mem[cur_set] <= wr_meta;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_init_r <= '0;
      init_rd_r  <= 1'b0;
    end else begin
      if (rd_en) begin
        init_rd_r <= row_init_r[rd_set];
      end
      if (wr_en) begin
        row_init_r[cur_set] <= 1'b1;
      end
    end
  end

  // Forward the demand fill when the prefetch lands in the same set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= (state_r == fcnlp_pkg::ST_DEMAND) && (next_set == cur_set);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == fcnlp_pkg::ST_DEMAND && wr_en) begin
      fwd_tags_r <= wr_tags;
      fwd_meta_r <= wr_meta;
    end
  end

  // Counters
  always_comb begin
    rd_cnt_nxt   = rd_cnt_r;
    wr_cnt_nxt   = wr_cnt_r;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (finish) begin
      rd_cnt_nxt   = fcnlp_pkg::sat_add(rd_cnt_r, reads_o);
      wr_cnt_nxt   = fcnlp_pkg::sat_add(wr_cnt_r, {1'b0, cmd_r});
      hit_cnt_nxt  = fcnlp_pkg::sat_add(hit_cnt_r, {1'b0, hit_o});
      miss_cnt_nxt = fcnlp_pkg::sat_add(miss_cnt_r, {1'b0, !hit_o});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r   <= '0;
      wr_cnt_r   <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else begin
      rd_cnt_r   <= rd_cnt_nxt;
      wr_cnt_r   <= wr_cnt_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r.hit          <= hit_o;
      out_data_r.reads_added  <= reads_o;
      out_data_r.write_added  <= cmd_r;
      out_data_r.total_reads  <= 32'(rd_cnt_nxt);
      out_data_r.total_writes <= 32'(wr_cnt_nxt);
      out_data_r.total_hits   <= 32'(hit_cnt_nxt);
      out_data_r.total_misses <= 32'(miss_cnt_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_result_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending transaction");

  a_prefetch_follows_demand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcnlp_pkg::ST_PREFETCH) |->
      ($past(state_r) == fcnlp_pkg::ST_DEMAND || $past(state_r) == fcnlp_pkg::ST_PREFETCH))
    else $error("prefetch lookup without a demand miss");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r != fcnlp_pkg::ST_IDLE))
    else $error("set row written while idle");

  a_reads_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (rd_cnt_r >= $past(rd_cnt_r)))
    else $error("read counter went backward");

  a_prefetch_miss_only: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && reads_o == 2'd2) |-> (!hit_o && state_r == fcnlp_pkg::ST_PREFETCH))
    else $error("prefetch fill without a preceding demand lookup");

endmodule

`default_nettype wire
